// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define TVRBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tvrbc assertion failed");
`define TVRBC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tvrbc assertion failed");
`else
`define TVRBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define TVRBC_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/tvrbc_pkg.sv =====
package tvrbc_pkg;

  localparam int MAX_ROUNDS = 64;
  localparam int RW         = $clog2(MAX_ROUNDS + 1);
  localparam int NUM_CELLS  = MAX_ROUNDS;
  localparam int ADDR_W     = 5;
  localparam int IDX_W      = 3;

  localparam logic [31:0] TEA_DELTA = 32'h9e37_79b9;

  localparam logic [IDX_W-1:0] REG_KEY0   = 3'd0;
  localparam logic [IDX_W-1:0] REG_KEY1   = 3'd1;
  localparam logic [IDX_W-1:0] REG_KEY2   = 3'd2;
  localparam logic [IDX_W-1:0] REG_KEY3   = 3'd3;
  localparam logic [IDX_W-1:0] REG_ROUNDS = 3'd4;

  typedef logic [3:0][31:0] key_t;

  typedef struct packed {
    logic          valid;
    logic          enc;
    logic [RW-1:0] rem;
    logic [31:0]   sum;
    logic [31:0]   y;
    logic [31:0]   z;
  } word_t;

  function automatic logic [31:0] mix(input logic [31:0] x, input logic [31:0] sum,
                                      input logic [31:0] kw);
    mix = ((x << 4) ^ (x >> 5)) + (x ^ sum) + kw;
  endfunction

endpackage

// ===== hw/rtl/tvrbc_half.sv =====
`include "assert_macros.svh"

module tvrbc_half (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             second,
  input  tvrbc_pkg::key_t  key,
  input  tvrbc_pkg::word_t d,
  output tvrbc_pkg::word_t q
);

  tvrbc_pkg::word_t q_r;
  tvrbc_pkg::word_t q_nxt;

  logic        is_a;
  logic        active;
  logic [31:0] src;
  logic [31:0] tgt;
  logic [1:0]  kidx;
  logic [31:0] m;
  logic [31:0] tgt_new;

  // enc: A then B; dec: B then A
  always_comb begin
    is_a    = d.enc ^ second;
    active  = (d.rem != '0);
    src     = is_a ? d.z : d.y;
    tgt     = is_a ? d.y : d.z;
    kidx    = is_a ? d.sum[1:0] : d.sum[12:11];
    m       = tvrbc_pkg::mix(src, d.sum, key[kidx]);
    tgt_new = d.enc ? (tgt + m) : (tgt - m);

    q_nxt = d;
    if (active) begin
      if (is_a) begin
        q_nxt.y = tgt_new;
      end else begin
        q_nxt.z = tgt_new;
      end
      if (!second) begin
        q_nxt.sum = d.enc ? (d.sum + tvrbc_pkg::TEA_DELTA) : (d.sum - tvrbc_pkg::TEA_DELTA);
      end else begin
        q_nxt.rem = d.rem - {{(tvrbc_pkg::RW-1){1'b0}}, 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r.enc <= q_nxt.enc;
      q_r.rem <= q_nxt.rem;
      q_r.sum <= q_nxt.sum;
      q_r.y   <= q_nxt.y;
      q_r.z   <= q_nxt.z;
    end
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r.valid <= q_nxt.valid;
    end
  end

  assign q = q_r;

  `TVRBC_ASSERT_NEXT(a_idle_pass, clk, rst_n, en && (d.rem == '0),
    q.y == $past(d.y) && q.z == $past(d.z) && q.sum == $past(d.sum))
  `TVRBC_ASSERT_NEXT(a_hold, clk, rst_n, !en,
    $stable(q.y) && $stable(q.z) && $stable(q.rem))
  `TVRBC_ASSERT_NEXT(a_sum_first, clk, rst_n, en && second, q.sum == $past(d.sum))

endmodule

// ===== hw/rtl/tvrbc_cell.sv =====
module tvrbc_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  tvrbc_pkg::key_t  key,
  input  tvrbc_pkg::word_t d,
  output tvrbc_pkg::word_t q
);

  tvrbc_pkg::word_t mid;

  tvrbc_half u_first (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .second (1'b0),
    .key    (key),
    .d      (d),
    .q      (mid)
  );

  tvrbc_half u_second (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .second (1'b1),
    .key    (key),
    .d      (mid),
    .q      (q)
  );

endmodule

// ===== hw/rtl/tea_variable_round_block_cipher.sv =====
// Pipeline: 2*MAX_ROUNDS (128) register stages, one register per half-round.
// Throughput: one word per cycle; the whole cell chain advances together and stalls
// only while the output word waits on out_ready.
// Reset (synchronous, rst_n low): pipeline emptied, key words cleared, round count 32.
// A round count write takes effect for the next accepted word.
module tea_variable_round_block_cipher (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [31:0]                    in_block_left,
  input  logic [31:0]                    in_block_right,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [31:0]                    out_result_left,
  output logic [31:0]                    out_result_right,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tvrbc_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int RW = tvrbc_pkg::RW;
  localparam int NC = tvrbc_pkg::NUM_CELLS;

  tvrbc_pkg::key_t   key_r;
  logic [7:0]        rounds_r;
  logic              enc_r;
  logic [RW-1:0]     mag_r;
  logic [31:0]       sum0_r;

  logic [tvrbc_pkg::IDX_W-1:0] idx;
  logic              wr;
  logic [8:0]        mag_full;
  logic [RW-1:0]     mag_nxt;
  logic              enc_nxt;
  logic [31:0]       sum0_nxt;

  logic              adv;
  tvrbc_pkg::word_t  chain [NC+1];

  assign pready = 1'b1;
  assign idx    = paddr[tvrbc_pkg::ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;

  always_comb begin
    mag_full = pwdata[7] ? (9'd256 - {1'b0, pwdata[7:0]}) : {1'b0, pwdata[7:0]};
    if (int'(mag_full) > tvrbc_pkg::MAX_ROUNDS) begin
      mag_nxt = RW'(tvrbc_pkg::MAX_ROUNDS);
    end else begin
      mag_nxt = RW'(mag_full);
    end
    enc_nxt  = !pwdata[7] && (pwdata[7:0] != 8'd0);
    sum0_nxt = enc_nxt ? 32'd0 : 32'(tvrbc_pkg::TEA_DELTA * 32'(mag_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r    <= '0;
      rounds_r <= 8'd32;
      enc_r    <= 1'b1;
      mag_r    <= RW'(32);
      sum0_r   <= 32'd0;
    end else if (wr) begin
      case (idx)
        tvrbc_pkg::REG_KEY0:   key_r[0] <= pwdata;
        tvrbc_pkg::REG_KEY1:   key_r[1] <= pwdata;
        tvrbc_pkg::REG_KEY2:   key_r[2] <= pwdata;
        tvrbc_pkg::REG_KEY3:   key_r[3] <= pwdata;
        tvrbc_pkg::REG_ROUNDS: begin
          rounds_r <= pwdata[7:0];
          enc_r    <= enc_nxt;
          mag_r    <= mag_nxt;
          sum0_r   <= sum0_nxt;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tvrbc_pkg::REG_KEY0:   prdata = key_r[0];
      tvrbc_pkg::REG_KEY1:   prdata = key_r[1];
      tvrbc_pkg::REG_KEY2:   prdata = key_r[2];
      tvrbc_pkg::REG_KEY3:   prdata = key_r[3];
      tvrbc_pkg::REG_ROUNDS: prdata = {24'd0, rounds_r};
      default:               prdata = 32'd0;
    endcase
  end

  assign adv      = !chain[NC].valid || out_ready;
  assign in_ready = adv;

  assign chain[0] = '{valid: in_valid, enc: enc_r, rem: mag_r, sum: sum0_r,
                      y: in_block_left, z: in_block_right};

  for (genvar k = 0; k < NC; k++) begin : g_cell
    tvrbc_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .key   (key_r),
      .d     (chain[k]),
      .q     (chain[k+1])
    );
  end

  assign out_valid        = chain[NC].valid;
  assign out_result_left  = chain[NC].y;
  assign out_result_right = chain[NC].z;

endmodule
